// ===== hw/rtl/pipo_pkg.sv =====
// Package with the cipher constants, request codes and the round functions.
package pipo_pkg;

  localparam int unsigned ROUNDS_DEF = 13;
  localparam int unsigned ROUND_W = 4;
  localparam int unsigned BLOCK_W = 64;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

  localparam logic [2:0] ROT_AMT [8] = '{3'd0, 3'd4, 3'd1, 3'd7, 3'd6, 3'd2, 3'd3, 3'd5};

  function automatic logic [BLOCK_W-1:0] sub_key(input logic [ROUND_W-1:0] r,
                                                 input logic [KEY_W-1:0] klo,
                                                 input logic [KEY_W-1:0] khi);
    return (r[0] ? khi : klo) ^ BLOCK_W'(r);
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input logic [2:0] n);
    logic [15:0] t;
    t = {x, x} << n;
    return t[15:8];
  endfunction

  function automatic logic [BLOCK_W-1:0] rot_layer(input logic [BLOCK_W-1:0] b,
                                                   input logic inv);
    logic [BLOCK_W-1:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = rotl8(b[8*i +: 8], inv ? 3'(3'd0 - ROT_AMT[i]) : ROT_AMT[i]);
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] s_layer(input logic [BLOCK_W-1:0] b);
    logic [7:0] x [8];
    logic [7:0] t0;
    logic [7:0] t1;
    logic [7:0] t2;
    logic [BLOCK_W-1:0] r;
    for (int i = 0; i < 8; i++) begin
      x[i] = b[8*i +: 8];
    end
    x[7] = x[7] ^ (x[5] & x[6]);
    x[4] = x[4] ^ (x[5] & x[7]);
    x[5] = x[5] ^ (x[4] | x[3]);
    x[6] = x[6] ^ x[4];
    x[3] = x[3] ^ x[7];
    x[7] = x[7] ^ (x[3] & x[6]);
    x[0] = x[0] ^ (x[2] & x[1]);
    x[1] = x[1] ^ (x[2] | x[0]);
    x[1] = ~x[1];
    x[2] = x[2] ^ (x[0] | x[1]);
    x[7] = x[7] ^ x[2];
    x[6] = x[6] ^ x[1];
    x[5] = x[5] ^ x[0];
    t0 = x[7];
    t1 = x[6];
    t2 = x[5];
    x[4] = x[4] ^ (x[3] & t0);
    x[4] = x[4] ^ t1;
    t2 = t2 ^ (x[4] | t1);
    t0 = t0 ^ t2;
    t1 = t1 ^ x[3];
    t2 = t2 | t1;
    x[3] = x[3] ^ (x[4] | t0);
    t2 = t2 ^ t0;
    x[2] = x[2] ^ t0;
    x[1] = x[1] ^ t2;
    x[0] = x[0] ^ t1;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = x[i];
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] inv_s_layer(input logic [BLOCK_W-1:0] b);
    logic [7:0] x [8];
    logic [7:0] t0;
    logic [7:0] t1;
    logic [7:0] t2;
    logic [7:0] t3;
    logic [BLOCK_W-1:0] r;
    for (int i = 0; i < 8; i++) begin
      x[i] = b[8*i +: 8];
    end
    t0 = x[7];
    t1 = x[6];
    t2 = x[5];
    t3 = x[7];
    t2 = t2 ^ (x[4] | t1);
    t0 = t0 ^ t2;
    x[3] = x[3] ^ (x[4] | t0);
    x[4] = x[4] ^ t1;
    t1 = t1 ^ x[3];
    t2 = t2 | t1;
    t2 = t2 ^ t0;
    x[4] = x[4] ^ (x[3] & t3);
    x[2] = x[2] ^ t0;
    x[1] = x[1] ^ t2;
    x[0] = x[0] ^ t1;
    x[7] = x[7] ^ x[2];
    x[6] = x[6] ^ x[1];
    x[5] = x[5] ^ x[0];
    x[7] = x[7] ^ (x[3] & x[6]);
    x[3] = x[3] ^ x[7];
    x[6] = x[6] ^ x[4];
    x[5] = x[5] ^ (x[4] | x[3]);
    x[4] = x[4] ^ (x[5] & x[7]);
    x[7] = x[7] ^ (x[5] & x[6]);
    x[2] = x[2] ^ (x[0] | x[1]);
    x[1] = ~x[1];
    x[1] = x[1] ^ (x[2] | x[0]);
    x[0] = x[0] ^ (x[2] & x[1]);
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = x[i];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/pipo64_block_cipher.sv =====
// Pipelined block cipher engine, one round per pipeline stage, both directions.
// An accepted request is captured in the input register and then passes through the round registers to the output.
// Throughput is one block per cycle while the result is not stalled; a stalled result freezes the whole pipeline.
// Reset clears all valid bits and both key registers; no clearing pass is needed.
// Keys are read live by every stage; the user must write them only while the pipeline is empty (not enforced here).
module pipo64_block_cipher #(
  parameter int unsigned ROUNDS = pipo_pkg::ROUNDS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pipo_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pipo_pkg::KEY_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic [pipo_pkg::BLOCK_W-1:0]       block_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pipo_pkg::BLOCK_W-1:0]       block_out_o
);

  logic [pipo_pkg::KEY_W-1:0] key_low_q;
  logic [pipo_pkg::KEY_W-1:0] key_high_q;
  logic [pipo_pkg::BLOCK_W-1:0] data_q [ROUNDS+1];
  logic [pipo_pkg::BLOCK_W-1:0] data_d [ROUNDS+1];
  logic [ROUNDS:0] valid_q;
  logic [ROUNDS:0] valid_d;
  logic [ROUNDS:0] cmd_q;
  logic [ROUNDS:0] cmd_d;
  logic advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q <= '0;
      key_high_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == pipo_pkg::REG_KEY_LOW) begin
        key_low_q <= cfg_data_i;
      end else if (cfg_index_i == pipo_pkg::REG_KEY_HIGH) begin
        key_high_q <= cfg_data_i;
      end
    end
  end

  assign advance = !(valid_q[ROUNDS] && out_stall_i);
  assign in_stall_o = !advance;

  assign data_d[0] = block_in_i;
  assign valid_d[0] = in_valid_i;
  assign cmd_d[0] = cmd_i;

  for (genvar s = 1; s <= ROUNDS; s++) begin : g_round
    localparam logic [pipo_pkg::ROUND_W-1:0] EncR = pipo_pkg::ROUND_W'(s);
    localparam logic [pipo_pkg::ROUND_W-1:0] DecR = pipo_pkg::ROUND_W'(ROUNDS + 1 - s);
    logic [pipo_pkg::BLOCK_W-1:0] enc_in;
    logic [pipo_pkg::BLOCK_W-1:0] enc_out;
    logic [pipo_pkg::BLOCK_W-1:0] dec_mid;
    logic [pipo_pkg::BLOCK_W-1:0] dec_out;
    logic [pipo_pkg::BLOCK_W-1:0] key0;

    always_comb begin
      key0 = pipo_pkg::sub_key('0, key_low_q, key_high_q);
      enc_in = (s == 1) ? (data_q[s-1] ^ key0) : data_q[s-1];
      enc_out = pipo_pkg::rot_layer(pipo_pkg::s_layer(enc_in), 1'b0)
                ^ pipo_pkg::sub_key(EncR, key_low_q, key_high_q);
      dec_mid = data_q[s-1] ^ pipo_pkg::sub_key(DecR, key_low_q, key_high_q);
      dec_out = pipo_pkg::inv_s_layer(pipo_pkg::rot_layer(dec_mid, 1'b1));
      if (s == ROUNDS) begin
        dec_out = dec_out ^ key0;
      end
    end

    assign data_d[s] = (cmd_q[s-1] == 1'(pipo_pkg::CMD_DECRYPT)) ? dec_out : enc_out;
    assign valid_d[s] = valid_q[s-1];
    assign cmd_d[s] = cmd_q[s-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cmd_q <= cmd_d;
      for (int i = 0; i <= ROUNDS; i++) begin
        data_q[i] <= data_d[i];
      end
    end
  end

  assign out_valid_o = valid_q[ROUNDS];
  assign block_out_o = data_q[ROUNDS];

`ifndef ASSERT_OFF
  a_stall_freezes_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(valid_q))
    else $error("pipeline valid bits moved while the result was stalled");

  a_accept_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> valid_q[0])
    else $error("accepted request did not enter the first stage");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the pipelined PIPO-64/128 encrypt and decrypt engine.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned PIPE_DEPTH = pipo_pkg::ROUNDS_DEF + 1;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam logic [pipo_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
  localparam logic [pipo_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;
  localparam logic [7:0][2:0] ROW_ROT = {3'd5, 3'd3, 3'd2, 3'd6, 3'd7, 3'd1, 3'd4, 3'd0};

  typedef struct packed {
    pipo_pkg::cmd_e dir;
    logic [pipo_pkg::BLOCK_W-1:0] blk;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pipo_pkg::CFG_IDX_W-1:0] cfg_index_i = pipo_pkg::REG_KEY_LOW;
  logic [pipo_pkg::KEY_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic cmd_i = pipo_pkg::CMD_ENCRYPT;
  logic [pipo_pkg::BLOCK_W-1:0] block_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [pipo_pkg::BLOCK_W-1:0] block_out_o;

  logic [pipo_pkg::KEY_W-1:0] key_lo_now = '0;
  logic [pipo_pkg::KEY_W-1:0] key_hi_now = '0;
  logic [pipo_pkg::BLOCK_W-1:0] awaited_blocks [$];
  logic [pipo_pkg::BLOCK_W-1:0] due_blk;
  int unsigned mismatch_cnt = 0;
  bit calm = 1'b0;

  stim_row_t dir_rows [12] = '{
    '{pipo_pkg::CMD_ENCRYPT, 64'h0000_0000_0000_0000},
    '{pipo_pkg::CMD_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF},
    '{pipo_pkg::CMD_DECRYPT, 64'h0000_0000_0000_0000},
    '{pipo_pkg::CMD_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF},
    '{pipo_pkg::CMD_ENCRYPT, 64'h0123_4567_89AB_CDEF},
    '{pipo_pkg::CMD_DECRYPT, 64'hFEDC_BA98_7654_3210},
    '{pipo_pkg::CMD_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA},
    '{pipo_pkg::CMD_DECRYPT, 64'h5555_5555_5555_5555},
    '{pipo_pkg::CMD_ENCRYPT, 64'h0000_0000_0000_0001},
    '{pipo_pkg::CMD_DECRYPT, 64'h8000_0000_0000_0000},
    '{pipo_pkg::CMD_ENCRYPT, 64'h0000_0000_FFFF_FFFF},
    '{pipo_pkg::CMD_DECRYPT, 64'hFFFF_FFFF_0000_0000}
  };

  pipo64_block_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .block_in_i  (block_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .block_out_o (block_out_o)
  );

  function automatic logic [pipo_pkg::KEY_W-1:0] round_subkey(int unsigned r);
    return ((r % 2 == 1) ? key_hi_now : key_lo_now) ^ 64'(r);
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] v, logic [2:0] n);
    return (v << n) | (v >> (4'd8 - {1'b0, n}));
  endfunction

  function automatic logic [pipo_pkg::BLOCK_W-1:0] pipo_transform(
      pipo_pkg::cmd_e dir, logic [pipo_pkg::BLOCK_W-1:0] blk);
    logic [7:0] x [8];
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic [pipo_pkg::KEY_W-1:0] k;
    logic [pipo_pkg::BLOCK_W-1:0] res;
    for (int i = 0; i < 8; i++) x[i] = blk[8*i +: 8];
    if (dir == pipo_pkg::CMD_ENCRYPT) begin
      k = round_subkey(0);
      for (int i = 0; i < 8; i++) x[i] ^= k[8*i +: 8];
      for (int r = 1; r <= pipo_pkg::ROUNDS_DEF; r++) begin
        x[7] ^= x[5] & x[6];
        x[4] ^= x[5] & x[7];
        x[5] ^= x[4] | x[3];
        x[6] ^= x[4];
        x[3] ^= x[7];
        x[7] ^= x[3] & x[6];
        x[0] ^= x[2] & x[1];
        x[1] ^= x[2] | x[0];
        x[1] = ~x[1];
        x[2] ^= x[0] | x[1];
        x[7] ^= x[2];
        x[6] ^= x[1];
        x[5] ^= x[0];
        a = x[7];
        b = x[6];
        c = x[5];
        x[4] ^= x[3] & a;
        x[4] ^= b;
        c ^= x[4] | b;
        a ^= c;
        b ^= x[3];
        c |= b;
        x[3] ^= x[4] | a;
        c ^= a;
        x[2] ^= a;
        x[1] ^= c;
        x[0] ^= b;
        for (int i = 0; i < 8; i++) x[i] = rol8(x[i], ROW_ROT[i]);
        k = round_subkey(r);
        for (int i = 0; i < 8; i++) x[i] ^= k[8*i +: 8];
      end
    end else begin
      for (int r = pipo_pkg::ROUNDS_DEF; r > 0; r--) begin
        k = round_subkey(r);
        for (int i = 0; i < 8; i++) x[i] ^= k[8*i +: 8];
        for (int i = 0; i < 8; i++) x[i] = rol8(x[i], 3'(3'd0 - ROW_ROT[i]));
        a = x[7];
        b = x[6];
        c = x[5];
        d = x[7];
        c ^= x[4] | b;
        a ^= c;
        x[3] ^= x[4] | a;
        x[4] ^= b;
        b ^= x[3];
        c |= b;
        c ^= a;
        x[4] ^= x[3] & d;
        x[2] ^= a;
        x[1] ^= c;
        x[0] ^= b;
        x[7] ^= x[2];
        x[6] ^= x[1];
        x[5] ^= x[0];
        x[7] ^= x[3] & x[6];
        x[3] ^= x[7];
        x[6] ^= x[4];
        x[5] ^= x[4] | x[3];
        x[4] ^= x[5] & x[7];
        x[7] ^= x[5] & x[6];
        x[2] ^= x[0] | x[1];
        x[1] = ~x[1];
        x[1] ^= x[2] | x[0];
        x[0] ^= x[2] & x[1];
      end
      k = round_subkey(0);
      for (int i = 0; i < 8; i++) x[i] ^= k[8*i +: 8];
    end
    for (int i = 0; i < 8; i++) res[8*i +: 8] = x[i];
    return res;
  endfunction

  task automatic cfg_write(logic [pipo_pkg::CFG_IDX_W-1:0] idx,
                           logic [pipo_pkg::KEY_W-1:0] val);
    logic took;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    if (idx == pipo_pkg::REG_KEY_LOW) key_lo_now = val;
    else if (idx == pipo_pkg::REG_KEY_HIGH) key_hi_now = val;
  endtask

  task automatic send_block(pipo_pkg::cmd_e dir, logic [pipo_pkg::BLOCK_W-1:0] blk);
    logic took;
    in_valid_i <= 1'b1;
    cmd_i <= dir;
    block_in_i <= blk;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    awaited_blocks.push_back(pipo_transform(dir, blk));
  endtask

  task automatic run_rows();
    foreach (dir_rows[i]) send_block(dir_rows[i].dir, dir_rows[i].blk);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (awaited_blocks.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic note_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!calm) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (awaited_blocks.size() == 0) begin
        note_error($sformatf("unexpected result %h with none pending", block_out_o));
      end else begin
        due_blk = awaited_blocks.pop_front();
        if (block_out_o !== due_blk) begin
          note_error($sformatf("block_out mismatch: expected %h got %h", due_blk, block_out_o));
        end
      end
    end
  end

  initial begin
    logic [pipo_pkg::KEY_W-1:0] lo;
    logic [pipo_pkg::KEY_W-1:0] hi;
    logic [pipo_pkg::BLOCK_W-1:0] blk;
    pipo_pkg::cmd_e dir;
    bit gaps;
    int unsigned sel;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_rows();
    drain();
    cfg_write(pipo_pkg::REG_KEY_LOW, '1);
    cfg_write(pipo_pkg::REG_KEY_HIGH, '1);
    cfg_write(REG_UNMAPPED_2, {$urandom, $urandom});
    cfg_write(REG_UNMAPPED_3, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    run_rows();
    for (int unsigned phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      if (phase == 0) begin
        lo = '0;
        hi = '1;
      end else if (phase == 1) begin
        lo = '1;
        hi = '0;
      end else begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end
      cfg_write(pipo_pkg::REG_KEY_LOW, lo);
      cfg_write(pipo_pkg::REG_KEY_HIGH, hi);
      if (phase % 2 == 1) cfg_write(REG_UNMAPPED_2, {$urandom, $urandom});
      else cfg_write(REG_UNMAPPED_3, {$urandom, $urandom});
      cfg_valid_i <= 1'b0;
      calm = (phase == RAND_PHASES - 1);
      gaps = !calm && (phase % 3 != 1);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        dir = pipo_pkg::cmd_e'($urandom_range(0, 1));
        sel = $urandom_range(0, 9);
        if (sel == 0) blk = 64'd1 << $urandom_range(0, 63);
        else if (sel == 1) blk = ~(64'd1 << $urandom_range(0, 63));
        else blk = {$urandom, $urandom};
        send_block(dir, blk);
        if (gaps && $urandom_range(0, 4) == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 13)) @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b0;
    end
    drain();
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== pipo64_block_cipher.f =====
hw/rtl/pipo_pkg.sv
hw/rtl/pipo64_block_cipher.sv
tb/tb_top.sv
